### rtl/core/sbsa_pkg.sv
// ----------------------------------------------------------------------------
// sbsa_pkg
// Shared types and constants for the shared bus slot arbiter.
// ----------------------------------------------------------------------------
package sbsa_pkg;

    localparam int SLOT_W        = 5;
    localparam int CFG_W         = 6;
    localparam int MAX_SLOTS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_ATTACH = 2'd0,
        KIND_DETACH = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_REPLY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_GRANTED = 2'd0,
        RES_REFUSED = 2'd1,
        RES_CALL    = 2'd2
    } res_kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic               busy_reply;
    } sbsa_item_t;

    typedef struct packed {
        logic               valid;
        res_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
    } sbsa_res_t;

endpackage

### rtl/core/sbsa_prio_enc.sv
// ----------------------------------------------------------------------------
// sbsa_prio_enc
// Highest-set-bit priority encoder over a slot mask.
// ----------------------------------------------------------------------------
module sbsa_prio_enc #(
    parameter int WIDTH = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic [WIDTH-1:0]            req,
    output logic                        any,
    output logic [sbsa_pkg::SLOT_W-1:0] idx
);
    import sbsa_pkg::*;

    always_comb
    begin
        any = 1'b0;
        idx = '0;
        // later (higher) bits override earlier ones
        for (int i = 0; i < WIDTH; i++)
        begin
            if (req[i])
            begin
                any = 1'b1;
                idx = SLOT_W'(i);
            end
        end
    end

endmodule

### rtl/core/sbsa_engine.sv
// ----------------------------------------------------------------------------
// sbsa_engine
// Arbitration state and the single-pass next-state logic for one word.
// ----------------------------------------------------------------------------
module sbsa_engine #(
    parameter int MAX_SLOTS = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sbsa_pkg::CFG_W-1:0] cfg_data,
    input  logic                       go,
    input  sbsa_pkg::sbsa_item_t       item,
    output sbsa_pkg::sbsa_res_t        res
);
    import sbsa_pkg::*;

    logic [CFG_W-1:0]     slots_in_use_reg;
    logic [MAX_SLOTS-1:0] free_reg,    free_next;
    logic [MAX_SLOTS-1:0] pending_reg, pending_next;
    logic [MAX_SLOTS-1:0] retire_reg,  retire_next;
    logic                 locked_reg,  locked_next;
    logic [SLOT_W-1:0]    owner_reg,   owner_next;
    logic                 awaiting_reg, awaiting_next;
    logic [SLOT_W-1:0]    called_reg,  called_next;
    logic                 recall_reg,  recall_next;

    logic [CFG_W-1:0]     used_cnt;
    logic [MAX_SLOTS-1:0] used_mask;
    logic [MAX_SLOTS-1:0] cfg_mask;
    logic [MAX_SLOTS-1:0] bit_s;
    logic                 usable;
    logic                 blocked;
    logic                 bus_idle;

    logic [MAX_SLOTS-1:0] pend_a;
    logic [MAX_SLOTS-1:0] ret_a;
    logic                 idle_req;
    logic [MAX_SLOTS-1:0] idle_pend;
    logic                 idle_any;
    logic [SLOT_W-1:0]    idle_top;
    logic [MAX_SLOTS-1:0] avail;
    logic                 avail_any;
    logic [SLOT_W-1:0]    avail_top;

    function automatic logic [CFG_W-1:0] clamp_cnt(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] n;
        n = v;
        if (n == '0)
            n = CFG_W'(1);
        if (n > CFG_W'(MAX_SLOTS))
            n = CFG_W'(MAX_SLOTS);
        return n;
    endfunction

    function automatic logic [MAX_SLOTS-1:0] cnt_mask(input logic [CFG_W-1:0] n);
        logic [MAX_SLOTS-1:0] m;
        for (int i = 0; i < MAX_SLOTS; i++)
            m[i] = CFG_W'(i) < n;
        return m;
    endfunction

    function automatic logic [MAX_SLOTS-1:0] slot_bit(input logic [SLOT_W-1:0] s);
        return MAX_SLOTS'(1) << s;
    endfunction

    assign used_cnt  = clamp_cnt(slots_in_use_reg);
    assign used_mask = cnt_mask(used_cnt);
    assign cfg_mask  = cnt_mask(clamp_cnt(cfg_data));
    assign bit_s     = slot_bit(item.slot);
    assign usable    = ({1'b0, item.slot} < used_cnt) && ((free_reg & bit_s) == '0);
    assign bus_idle  = !locked_reg && !awaiting_reg;
    assign blocked   = ((retire_reg & bit_s) != '0) &&
                       !(locked_reg && !awaiting_reg && owner_reg == item.slot);

    // masks as they stand just before a possible idle point
    always_comb
    begin
        pend_a   = pending_reg;
        ret_a    = retire_reg;
        idle_req = 1'b0;
        case (item.kind)
            KIND_DETACH:
            begin
                if (usable)
                begin
                    ret_a    = retire_reg | bit_s;
                    idle_req = bus_idle;
                end
            end
            KIND_UPDATE:
            begin
                if (usable && !blocked && bus_idle)
                begin
                    pend_a   = pending_reg | bit_s;
                    idle_req = 1'b1;
                end
            end
            KIND_REPLY:
            begin
                if (awaiting_reg && !item.busy_reply)
                begin
                    if (recall_reg)
                        pend_a = pending_reg | slot_bit(called_reg);
                    idle_req = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign idle_pend = pend_a & ~ret_a & used_mask;
    assign avail     = free_reg & used_mask;

    sbsa_prio_enc #(.WIDTH(MAX_SLOTS)) u_idle_enc (
        .req (idle_pend),
        .any (idle_any),
        .idx (idle_top)
    );

    sbsa_prio_enc #(.WIDTH(MAX_SLOTS)) u_attach_enc (
        .req (avail),
        .any (avail_any),
        .idx (avail_top)
    );

    always_comb
    begin
        free_next     = free_reg;
        pending_next  = pending_reg;
        retire_next   = retire_reg;
        locked_next   = locked_reg;
        owner_next    = owner_reg;
        awaiting_next = awaiting_reg;
        called_next   = called_reg;
        recall_next   = recall_reg;
        res           = '{valid: 1'b0, kind: RES_GRANTED, slot: '0};

        case (item.kind)
            KIND_ATTACH:
            begin
                res.valid = 1'b1;
                if (avail_any)
                begin
                    free_next = free_reg & ~slot_bit(avail_top);
                    res.kind  = RES_GRANTED;
                    res.slot  = avail_top;
                end
                else
                begin
                    res.kind = RES_REFUSED;
                end
            end
            KIND_DETACH:
            begin
                if (usable)
                    retire_next = ret_a;
            end
            KIND_UPDATE:
            begin
                if (usable && !blocked)
                begin
                    if (awaiting_reg)
                    begin
                        if (item.slot == called_reg)
                            recall_next = 1'b1;
                        else
                            pending_next = pending_reg | bit_s;
                    end
                    else if (locked_reg)
                    begin
                        if (item.slot == owner_reg)
                        begin
                            // owner holds the bus: call it straight away
                            pending_next  = pending_reg & ~bit_s;
                            awaiting_next = 1'b1;
                            called_next   = item.slot;
                            res = '{valid: 1'b1, kind: RES_CALL, slot: item.slot};
                        end
                        else
                        begin
                            pending_next = pending_reg | bit_s;
                        end
                    end
                end
            end
            KIND_REPLY:
            begin
                if (awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    recall_next   = 1'b0;
                    if (item.busy_reply)
                    begin
                        locked_next = 1'b1;
                        owner_next  = called_reg;
                        if (recall_reg)
                        begin
                            pending_next  = pending_reg & ~slot_bit(called_reg);
                            awaiting_next = 1'b1;
                            res = '{valid: 1'b1, kind: RES_CALL, slot: called_reg};
                        end
                    end
                    else
                    begin
                        locked_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // idle point: retire marked slots, then call the top pending slot
        if (idle_req)
        begin
            free_next    = free_reg | ret_a;
            retire_next  = '0;
            pending_next = idle_pend;
            if (idle_any)
            begin
                pending_next  = idle_pend & ~slot_bit(idle_top);
                awaiting_next = 1'b1;
                called_next   = idle_top;
                res = '{valid: 1'b1, kind: RES_CALL, slot: idle_top};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= CFG_W'(32);
            free_reg         <= '1;
            pending_reg      <= '0;
            retire_reg       <= '0;
            locked_reg       <= 1'b0;
            owner_reg        <= '0;
            awaiting_reg     <= 1'b0;
            called_reg       <= '0;
            recall_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            // bus state is kept across a register write
            slots_in_use_reg <= cfg_data;
            free_reg         <= cfg_mask;
            pending_reg      <= '0;
            retire_reg       <= '0;
            recall_reg       <= 1'b0;
        end
        else if (go)
        begin
            free_reg     <= free_next;
            pending_reg  <= pending_next;
            retire_reg   <= retire_next;
            locked_reg   <= locked_next;
            owner_reg    <= owner_next;
            awaiting_reg <= awaiting_next;
            called_reg   <= called_next;
            recall_reg   <= recall_next;
        end
    end

endmodule

### rtl/core/shared_bus_slot_arbiter_top.sv
// ----------------------------------------------------------------------------
// shared_bus_slot_arbiter_top
// Fixed-priority arbiter of one shared bus among device slots, with bus lock.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one word per event: attach,
// detach, update request or device reply. Output channel (out_valid /
// out_stall) carries at most one result word per input word: attach granted,
// attach refused, or call a device.
// An accepted word is held in the input register; the state is updated as it
// moves on to the result register, and its result then shows on out_valid.
// One word per cycle while out_stall is low; the limit is the 32-bit
// priority encode plus mask update between the input and result registers.
// A word that gives no result still needs the result register to be free
// before it moves on. While out_stall holds a result, in_stall rises once the
// input register is full; nothing is dropped.
// cfg_we/cfg_data write slots_in_use; free slots are refilled. Writes are
// for the user to make only while idle; the block does not enforce it.
// Reset: all usable slots free, nothing pending, bus idle, slots_in_use 32.
// ----------------------------------------------------------------------------
module shared_bus_slot_arbiter_top #(
    parameter int MAX_SLOTS = sbsa_pkg::MAX_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sbsa_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [sbsa_pkg::SLOT_W-1:0] slot,
    input  logic                        busy_reply,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  result_kind,
    output logic [sbsa_pkg::SLOT_W-1:0] out_slot
);
    import sbsa_pkg::*;

    logic       in_full_reg;
    sbsa_item_t item_reg;
    logic       out_full_reg;
    res_kind_t  res_kind_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic       adv;
    logic       accept;
    sbsa_res_t  res;

    assign adv      = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !adv;
    assign accept   = in_valid && !in_stall;

    sbsa_engine #(.MAX_SLOTS(MAX_SLOTS)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .go       (adv),
        .item     (item_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_full_reg <= 1'b1;
            else if (adv)
                in_full_reg <= 1'b0;

            if (adv)
                out_full_reg <= res.valid;
            else if (!out_stall)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= '{kind: kind_t'(kind), slot: slot, busy_reply: busy_reply};
        if (adv)
        begin
            res_kind_reg <= res.kind;
            res_slot_reg <= res.slot;
        end
    end

    assign out_valid   = out_full_reg;
    assign result_kind = res_kind_reg;
    assign out_slot    = res_slot_reg;

endmodule

### rtl/core/sbsa_checker.sv
// ----------------------------------------------------------------------------
// sbsa_checker
// Port-level checks on the shared bus slot arbiter, bound to the top level.
// ----------------------------------------------------------------------------
module sbsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  result_kind,
    input logic [sbsa_pkg::SLOT_W-1:0] out_slot
);
    import sbsa_pkg::*;

    // a held result word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(out_slot))
        else $error("result word changed while stalled");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with result side free");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == RES_GRANTED || result_kind == RES_REFUSED ||
                      result_kind == RES_CALL)
        else $error("unknown result code");

    a_refuse_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_REFUSED |-> out_slot == '0)
        else $error("refusal carries a slot");

endmodule

bind shared_bus_slot_arbiter_top sbsa_checker u_sbsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .out_slot    (out_slot)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared bus slot arbiter. A queue of directed
// and random event words feeds a clocked driver; each accepted word is run
// through a local slot/bus model and its result, if any, is queued. A clocked
// monitor compares every result word field by field against that queue.
// Both channels idle at random; slots_in_use is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import sbsa_pkg::*;

    localparam int SLOTS        = MAX_SLOTS_DEF;
    localparam int QUIET_CYCLES = 8;

    typedef struct {
        bit               is_cfg;
        bit               hold;
        logic [CFG_W-1:0] cfg;
        sbsa_item_t       item;
    } stim_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [CFG_W-1:0]    cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [1:0]          kind       = '0;
    logic [SLOT_W-1:0]   slot       = '0;
    logic                busy_reply = 1'b0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [1:0]          result_kind;
    logic [SLOT_W-1:0]   out_slot;

    stim_t      stim_q[$];
    sbsa_res_t  want_q[$];
    sbsa_item_t cur;
    int         mismatches = 0;
    int         taken      = 0;
    int         quiet      = 0;
    logic       calm;

    // long stretch with no idling on either side
    assign calm = (taken >= 800) && (taken < 1100);

    shared_bus_slot_arbiter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .slot       (slot),
        .busy_reply (busy_reply),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_kind(result_kind),
        .out_slot   (out_slot)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Slot and bus model
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  arb_count;
    logic [31:0]       arb_free;
    logic [31:0]       arb_pend;
    logic [31:0]       arb_retire;
    logic              arb_locked;
    logic              arb_await;
    logic              arb_recall;
    logic [SLOT_W-1:0] arb_owner;
    logic [SLOT_W-1:0] arb_called;

    function automatic int live_slots();
        int n;
        n = arb_count;
        if (n < 1)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        return n;
    endfunction

    function automatic logic [31:0] live_mask();
        int n;
        n = live_slots();
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
    endfunction

    function automatic logic [SLOT_W-1:0] top_slot(logic [31:0] m);
        for (int i = 31; i > 0; i--)
            if (m[i])
                return SLOT_W'(i);
        return '0;
    endfunction

    function automatic sbsa_res_t call_device(logic [SLOT_W-1:0] s);
        sbsa_res_t r;
        arb_pend[s] = 1'b0;
        arb_await   = 1'b1;
        arb_called  = s;
        r.valid = 1'b1;
        r.kind  = RES_CALL;
        r.slot  = s;
        return r;
    endfunction

    // only reached with the bus idle: retire marked slots, then dispatch
    function automatic sbsa_res_t bus_idle_point();
        sbsa_res_t r;
        r = '0;
        arb_free   |= arb_retire;
        arb_pend   &= ~arb_retire;
        arb_retire  = '0;
        arb_pend   &= live_mask();
        if (arb_pend != 0)
            r = call_device(top_slot(arb_pend));
        return r;
    endfunction

    function automatic void arb_write_count(logic [CFG_W-1:0] v);
        arb_count  = v;
        arb_free   = live_mask();
        arb_pend   = '0;
        arb_retire = '0;
        arb_recall = 1'b0;
    endfunction

    function automatic void arb_reset();
        arb_write_count(CFG_W'(32));
        arb_locked = 1'b0;
        arb_await  = 1'b0;
        arb_owner  = '0;
        arb_called = '0;
    endfunction

    function automatic sbsa_res_t arb_step(sbsa_item_t it);
        sbsa_res_t         r;
        logic [31:0]       bit_m;
        logic [31:0]       avail;
        logic              ok;
        logic [SLOT_W-1:0] s;
        r     = '0;
        s     = it.slot;
        bit_m = 32'd1 << s;
        ok    = (int'(s) < live_slots()) && ((arb_free & bit_m) == 0);
        case (it.kind)
            KIND_ATTACH:
            begin
                avail   = arb_free & live_mask();
                r.valid = 1'b1;
                if (avail == 0)
                begin
                    r.kind = RES_REFUSED;
                    r.slot = '0;
                end
                else
                begin
                    s           = top_slot(avail);
                    arb_free[s] = 1'b0;
                    r.kind      = RES_GRANTED;
                    r.slot      = s;
                end
            end
            KIND_DETACH:
            begin
                if (ok)
                begin
                    arb_retire |= bit_m;
                    if (!arb_locked && !arb_await)
                        r = bus_idle_point();
                end
            end
            KIND_UPDATE:
            begin
                // a retiring slot may only speak as lock owner, to let go
                if (ok && !(arb_retire[s] &&
                            !(arb_locked && !arb_await && arb_owner == s)))
                begin
                    if (arb_await)
                    begin
                        if (s == arb_called)
                            arb_recall = 1'b1;
                        else
                            arb_pend |= bit_m;
                    end
                    else if (arb_locked)
                    begin
                        if (s == arb_owner)
                            r = call_device(s);
                        else
                            arb_pend |= bit_m;
                    end
                    else
                    begin
                        arb_pend |= bit_m;
                        r = bus_idle_point();
                    end
                end
            end
            KIND_REPLY:
            begin
                if (arb_await)
                begin
                    arb_await = 1'b0;
                    if (it.busy_reply)
                    begin
                        arb_locked = 1'b1;
                        arb_owner  = arb_called;
                        if (arb_recall)
                        begin
                            arb_recall = 1'b0;
                            r = call_device(arb_called);
                        end
                    end
                    else
                    begin
                        arb_locked = 1'b0;
                        if (arb_recall)
                        begin
                            arb_recall           = 1'b0;
                            arb_pend[arb_called] = 1'b1;
                        end
                        r = bus_idle_point();
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= KIND_ATTACH;
            slot       <= '0;
            busy_reply <= 1'b0;
            cfg_we     <= 1'b0;
            cfg_data   <= '0;
            quiet = 0;
            arb_reset();
        end
        else
        begin : drive
            sbsa_res_t res;
            logic      nv;
            logic      we_n;
            we_n = 1'b0;
            if (in_valid && !in_stall)
            begin
                res = arb_step(cur);
                if (res.valid)
                    want_q.push_back(res);
                taken++;
            end
            if (!in_valid || !in_stall)
            begin
                nv = 1'b0;
                if (stim_q.size() != 0)
                begin
                    if (stim_q[0].hold)
                    begin
                        // let the block drain fully before moving on
                        if (!in_valid && want_q.size() == 0)
                            quiet++;
                        else
                            quiet = 0;
                        if (quiet >= QUIET_CYCLES)
                        begin
                            if (stim_q[0].is_cfg)
                            begin
                                we_n = 1'b1;
                                cfg_data <= stim_q[0].cfg;
                                arb_write_count(stim_q[0].cfg);
                            end
                            quiet = 0;
                            void'(stim_q.pop_front());
                        end
                    end
                    else if (calm || $urandom_range(99) >= 27)
                    begin
                        cur = stim_q[0].item;
                        void'(stim_q.pop_front());
                        nv = 1'b1;
                        kind       <= cur.kind;
                        slot       <= cur.slot;
                        busy_reply <= cur.busy_reply;
                    end
                end
                in_valid <= nv;
            end
            cfg_we <= we_n;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin : watch
            sbsa_res_t exp_r;
            if (out_valid && !out_stall)
            begin
                if (want_q.size() == 0)
                begin
                    $error("unexpected result word: result_kind %0d out_slot %0d",
                           result_kind, out_slot);
                    mismatches++;
                end
                else
                begin
                    exp_r = want_q.pop_front();
                    if (result_kind !== exp_r.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind);
                        mismatches++;
                    end
                    if (out_slot !== exp_r.slot)
                    begin
                        $error("out_slot: expected %0d, got %0d", exp_r.slot, out_slot);
                        mismatches++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void push_item(kind_t k, int s, bit b);
        stim_t e;
        e.is_cfg          = 1'b0;
        e.hold            = 1'b0;
        e.cfg             = '0;
        e.item.kind       = k;
        e.item.slot       = SLOT_W'(s);
        e.item.busy_reply = b;
        stim_q.push_back(e);
    endfunction

    function automatic void push_hold(bit is_cfg, logic [CFG_W-1:0] v);
        stim_t e;
        e.is_cfg = is_cfg;
        e.hold   = 1'b1;
        e.cfg    = v;
        e.item   = '0;
        stim_q.push_back(e);
    endfunction

    function automatic void random_phase(logic [CFG_W-1:0] v, int n, bit pause_mid);
        int used;
        int r;
        int s;
        push_hold(1'b1, v);
        used = (v < 1) ? 1 : ((v > SLOTS) ? SLOTS : int'(v));
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                push_hold(1'b0, '0);
            r = $urandom_range(99);
            // mostly slots in range; a few strays anywhere
            s = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(used - 1);
            if (r < 22)
                push_item(KIND_ATTACH, $urandom_range(31), $urandom_range(1));
            else if (r < 36)
                push_item(KIND_DETACH, s, $urandom_range(1));
            else if (r < 70)
                push_item(KIND_UPDATE, s, $urandom_range(1));
            else
                push_item(KIND_REPLY, $urandom_range(31), $urandom_range(99) < 40);
        end
    endfunction

    initial
    begin
        // reset config: 32 slots
        push_item(KIND_ATTACH, 0, 0);
        push_item(KIND_ATTACH, 0, 0);
        push_item(KIND_ATTACH, 0, 0);
        push_item(KIND_UPDATE, 31, 0);
        push_item(KIND_UPDATE, 31, 0);      // called slot asks again: recall
        push_item(KIND_UPDATE, 30, 0);      // other slot while awaiting: pending
        push_item(KIND_REPLY, 0, 1);        // busy with recall: call again
        push_item(KIND_REPLY, 0, 1);        // busy: lock stays with 31
        push_item(KIND_UPDATE, 29, 0);      // locked, not owner: pending
        push_item(KIND_DETACH, 30, 0);      // detach while busy
        push_item(KIND_DETACH, 30, 0);      // repeated detach
        push_item(KIND_UPDATE, 30, 0);      // retiring slot: ignored
        push_item(KIND_DETACH, 31, 0);
        push_item(KIND_UPDATE, 31, 0);      // retiring owner may still call
        push_item(KIND_REPLY, 0, 0);        // idle point: retire, call 29
        push_item(KIND_UPDATE, 29, 0);
        push_item(KIND_REPLY, 0, 0);        // recall on not-busy: pending again
        push_item(KIND_REPLY, 31, 0);
        push_item(KIND_REPLY, 31, 1);       // stray reply
        push_item(KIND_DETACH, 5, 1);       // free slot: ignored
        push_item(KIND_UPDATE, 5, 1);
        // zero counts as one slot
        push_hold(1'b1, CFG_W'(0));
        push_item(KIND_ATTACH, 0, 0);
        push_item(KIND_ATTACH, 0, 0);       // refused
        push_item(KIND_UPDATE, 31, 0);      // beyond used count

        random_phase(CFG_W'(4), 130, 1'b0);
        random_phase(CFG_W'(1), 100, 1'b0);
        random_phase(CFG_W'(8), 140, 1'b1);
        random_phase(CFG_W'(63), 140, 1'b0);
        random_phase(CFG_W'(2), 110, 1'b0);
        random_phase(CFG_W'(32), 160, 1'b0);
        random_phase(CFG_W'(0), 60, 1'b0);
        random_phase(CFG_W'(17), 150, 1'b0);
        random_phase(CFG_W'(40), 140, 1'b0);
        random_phase(CFG_W'($urandom_range(1, 32)), 150, 1'b0);
        random_phase(CFG_W'(3), 150, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid || want_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/sbsa_pkg.sv
rtl/core/sbsa_prio_enc.sv
rtl/core/sbsa_engine.sv
rtl/core/shared_bus_slot_arbiter_top.sv
rtl/core/sbsa_checker.sv
sim/tb_top.sv
